// ===== rtl/core/wbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

   // Window and pattern geometry.
   localparam int MAX_PATTERN = 32;
   localparam int PAT_BYTES   = 32;
   localparam int PAT_WORDS   = 4;
   localparam int WORD_W      = 64;
   localparam int PAT_BITS    = PAT_WORDS * WORD_W;
   localparam int PB_W        = $clog2(PAT_BYTES);
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int CFG_LEN_W   = 6;
   localparam int OFFSET_W    = 32;

   // Register file layout.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WILDCARD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH    = 3'd5;

   // Pattern laid out against the window: want[j] is the byte expected at
   // window slot j, care[j] says whether slot j takes part in the compare.
   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] want;
      logic [MAX_PATTERN-1:0]      care;
      logic [LEN_W-1:0]            len;
   } align_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
   } result_type;

   // Clamps the length to 1..MAX_PATTERN and lines the pattern up with the
   // newest bytes of the window.
   function automatic align_type align_pattern(
      input logic [PAT_BITS-1:0]  pat,
      input logic [PAT_BYTES-1:0] wild,
      input logic [CFG_LEN_W-1:0] plen
   );
      align_type        al;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] base;
      logic [LEN_W-1:0] pos;
      if (plen == '0) begin
         len = LEN_W'(1);
      end else if (int'(plen) > MAX_PATTERN) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = LEN_W'(plen);
      end
      base   = LEN_W'(MAX_PATTERN) - len;
      al.len = len;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pos        = LEN_W'(j) - base;
         al.care[j] = 1'b0;
         al.want[j] = 8'd0;
         if (LEN_W'(j) >= base && int'(pos) < PAT_BYTES) begin
            if (!wild[pos[PB_W-1:0]]) begin
               al.care[j] = 1'b1;
               al.want[j] = pat[{pos[PB_W-1:0], 3'b000} +: 8];
            end
         end
      end
      return al;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wbps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wbps_req_if;
   import wbps_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] mem_byte;
   logic       last_byte;

   modport source (output valid, output mem_byte, output last_byte, input ready);
   modport sink   (input valid, input mem_byte, input last_byte, output ready);
endinterface

interface wbps_rsp_if;
   import wbps_pkg::*;
   logic                valid;
   logic                ready;
   logic                found;
   logic [OFFSET_W-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_csr_if;
   import wbps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wbps_csr_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbps_csr_regs
   import wbps_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   wbps_csr_if.sink    csr_bus,
   output align_type   align_cfg
);

   logic [PAT_BITS-1:0]  pat_ff,   pat_in;
   logic [PAT_BYTES-1:0] wild_ff,  wild_in;
   logic [CFG_LEN_W-1:0] plen_ff,  plen_in;
   align_type            align_ff, align_in;
   logic                 wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   always_comb begin
      pat_in  = pat_ff;
      wild_in = wild_ff;
      plen_in = plen_ff;
      if (wr_en) begin
         case (csr_bus.reg_index)
            CSR_PATTERN_0: pat_in[0*WORD_W +: WORD_W] = csr_bus.wdata;
            CSR_PATTERN_1: pat_in[1*WORD_W +: WORD_W] = csr_bus.wdata;
            CSR_PATTERN_2: pat_in[2*WORD_W +: WORD_W] = csr_bus.wdata;
            CSR_PATTERN_3: pat_in[3*WORD_W +: WORD_W] = csr_bus.wdata;
            CSR_WILDCARD:  wild_in = csr_bus.wdata[PAT_BYTES-1:0];
            CSR_LENGTH:    plen_in = csr_bus.wdata[CFG_LEN_W-1:0];
            default: ;
         endcase
      end
      // Built from the next register values so a compare in the following
      // cycle already sees a fresh write.
      align_in = align_pattern(pat_in, wild_in, plen_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff   <= '0;
         wild_ff  <= '0;
         plen_ff  <= CFG_LEN_W'(1);
         align_ff <= align_pattern('0, '0, CFG_LEN_W'(1));
      end else begin
         pat_ff   <= pat_in;
         wild_ff  <= wild_in;
         plen_ff  <= plen_in;
         align_ff <= align_in;
      end
   end

   assign align_cfg = align_ff;

endmodule

`default_nettype wire

// ===== rtl/core/wbps_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbps_match
   import wbps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   wbps_req_if.sink        req_bus,
   input  wire align_type  align_cfg,
   input  wire logic       out_ready,
   output logic            res_push,
   output result_type      res_data
);

   logic [MAX_PATTERN-1:0][7:0] window_ff, window_in;
   logic [OFFSET_W-1:0]         bytes_seen_ff, bytes_seen_in;
   logic                        match_done_ff, match_done_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_last_ff, s1_last_in;

   logic                        req_accept;
   logic                        s1_fire;
   logic                        region_end;
   logic [MAX_PATTERN-1:0]      slot_ok;
   logic                        hit;
   logic                        long_enough;
   logic                        found;
   logic [OFFSET_W-1:0]         count_base;

   assign s1_fire       = s1_valid_ff && out_ready;
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign region_end    = s1_fire && s1_last_ff;

   // Parallel compare of the window against the lined-up pattern.
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         slot_ok[j] = !align_cfg.care[j] || (window_ff[j] == align_cfg.want[j]);
      end
   end

   assign hit         = &slot_ok;
   assign long_enough = bytes_seen_ff >= OFFSET_W'(align_cfg.len);
   assign found       = !match_done_ff && long_enough && hit;

   assign res_push               = s1_fire && (found || (s1_last_ff && !match_done_ff));
   assign res_data.found         = found;
   assign res_data.match_offset  = found ? (bytes_seen_ff - OFFSET_W'(align_cfg.len))
                                         : '0;

   always_comb begin
      count_base = region_end ? '0 : bytes_seen_ff;
      window_in  = window_ff;
      if (req_accept) begin
         window_in = {req_bus.mem_byte, window_ff[MAX_PATTERN-1:1]};
      end

      bytes_seen_in = count_base;
      if (req_accept && count_base != '1) begin
         bytes_seen_in = count_base + OFFSET_W'(1);
      end

      match_done_in = match_done_ff;
      if (region_end) begin
         match_done_in = 1'b0;
      end else if (s1_fire && found) begin
         match_done_in = 1'b1;
      end

      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_last_in  = req_bus.last_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         match_done_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s1_last_ff    <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         match_done_ff <= match_done_in;
         s1_valid_ff   <= s1_valid_in;
         s1_last_ff    <= s1_last_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   // A byte waiting for its compare has always been counted.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> bytes_seen_ff != '0)
      else $error("byte pending with zero byte count");

   // A match in mid-region locks out further results.
   a_done_after_match: assert property (@(posedge clock) disable iff (reset)
      res_push && res_data.found && !s1_last_ff |=> match_done_ff)
      else $error("match not recorded");

   // Only one found result per region.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      match_done_ff && s1_fire |-> !found)
      else $error("second match reported in one region");

   // The end of a region restarts the count unless a new byte came in.
   a_region_restart: assert property (@(posedge clock) disable iff (reset)
      region_end && !req_accept |=> bytes_seen_ff == '0 && !match_done_ff)
      else $error("region state not cleared");

endmodule

`default_nettype wire

// ===== rtl/core/wbps_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbps_out_stage
   import wbps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_push,
   input  wire result_type res_data,
   output logic            out_ready,
   wbps_rsp_if.source      rsp_bus
);

   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       pop;
   logic       push_ok;

   assign out_ready = !skid_valid_ff;
   assign pop       = main_valid_ff && rsp_bus.ready;
   assign push_ok   = res_push && out_ready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_ok) begin
         if (!main_valid_ff || pop) begin
            main_in       = res_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = res_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid        = main_valid_ff;
   assign rsp_bus.found        = main_ff.found;
   assign rsp_bus.match_offset = main_ff.match_offset;

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_byte_pattern_scan_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake     Payload
// req_bus   in   valid/ready   mem_byte[7:0], last_byte
// rsp_bus   out  valid/ready   found, match_offset[31:0]
// csr_bus   in   valid/ready   reg_index[2:0], wdata[63:0]
//
// One byte is accepted per cycle while req_bus ready is high; its result, if
// any, passes through the window register and then the result register.
// The compare is a single parallel pass over the 32-byte window.
// Reset is synchronous and clears the region state; the pattern registers
// return to zero, the wildcard mask to zero and the length to one.
// A stalled rsp_bus is absorbed by a two-entry output stage, and req_bus
// ready drops once both entries hold results and a further byte waits in
// the window stage.

module wildcard_byte_pattern_scan_unit
   import wbps_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   wbps_req_if.sink   req_bus,
   wbps_rsp_if.source rsp_bus,
   wbps_csr_if.sink   csr_bus
);

   align_type  align_cfg;
   logic       out_ready;
   logic       res_push;
   result_type res_data;

   // Configuration registers. They also precompute the pattern lined up with
   // the newest bytes of the window, so the compare path stays short.
   wbps_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_bus   (csr_bus),
      .align_cfg (align_cfg)
   );

   // Byte window, region byte count and the match compare. A request is
   // held in the window stage until the output stage has room for it.
   wbps_match u_match (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .align_cfg (align_cfg),
      .out_ready (out_ready),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // Result register with a skid entry, so input acceptance never depends
   // combinationally on the downstream ready.
   wbps_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res_data  (res_data),
      .out_ready (out_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== tb/wildcard_byte_pattern_scan_unit_tb.sv =====
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_unit_tb;
   import wbps_pkg::*;

   // The run is short, so this limit is far above any correct run, even one
   // where every request waits out the longest stalls on both sides.
   localparam int CYCLE_LIMIT   = 1_000_000;
   // Settling time allowed before the block is treated as idle.
   localparam int SETTLE_CYCLES = 6;
   // Length of the receiver hold-off used to fill the output stage.
   localparam int LONG_HOLD     = 250;
   // Upper bound on the wait for stragglers at the very end.
   localparam int DRAIN_LIMIT   = 5000;

   logic clock;
   logic reset;

   wbps_req_if req_bus ();
   wbps_rsp_if rsp_bus ();
   wbps_csr_if csr_bus ();

   wildcard_byte_pattern_scan_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Our own copy of the configuration registers, updated on each accepted
   // write, and of the per-region scan state.
   logic [CSR_DATA_W-1:0] pat_words [PAT_WORDS];
   logic [31:0]           wild_bits;
   logic [CFG_LEN_W-1:0]  pat_len_cfg;
   logic [7:0]            win_bytes [MAX_PATTERN];
   logic [OFFSET_W-1:0]   region_bytes;
   logic                  region_hit;

   // Outcomes (match or not-found) predicted but not yet seen on rsp_bus.
   result_type pending_outcomes [$];

   // Random idling on either side, and a request for a long receiver hold.
   bit src_idling       = 1'b0;
   bit snk_idling       = 1'b0;
   int rsp_hold_request = 0;

   int cycle_count    = 0;
   int bytes_sent     = 0;
   int regions_sent   = 0;
   int hits_seen      = 0;
   int misses_seen    = 0;
   int mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d outcomes still pending",
               cycle_count, pending_outcomes.size());
      $display("wildcard_byte_pattern_scan_unit_tb: errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Scan predictor
   // ------------------------------------------------------------------

   function automatic void clear_region_state();
      foreach (win_bytes[i]) win_bytes[i] = 8'd0;
      region_bytes = '0;
      region_hit   = 1'b0;
   endfunction

   // A length of zero behaves as one, anything above the window as the
   // full window.
   function automatic int unsigned active_length();
      if (pat_len_cfg == '0) return 1;
      if (pat_len_cfg > MAX_PATTERN) return MAX_PATTERN;
      return pat_len_cfg;
   endfunction

   function automatic logic [7:0] pattern_byte(input int unsigned pos);
      return pat_words[pos / 8][(pos % 8) * 8 +: 8];
   endfunction

   // Shifts one byte into the window and queues the outcome it causes, if
   // any. Pattern byte len-1 lines up with the newest byte, so a trailing
   // wildcard still needs a byte of memory after the matched bytes.
   function automatic void predict_scan_result(input logic [7:0] value, input logic last);
      int unsigned len;
      logic        hit;
      result_type  outcome;
      for (int i = 0; i < MAX_PATTERN - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[MAX_PATTERN - 1] = value;
      // The count saturates; a run never gets near that, but the predictor
      // follows the rule anyway.
      if (region_bytes != '1) region_bytes++;
      len = active_length();
      hit = !region_hit && (region_bytes >= len);
      for (int i = 0; i < len; i++) begin
         if (!wild_bits[i] && pattern_byte(i) != win_bytes[MAX_PATTERN - len + i]) begin
            hit = 1'b0;
         end
      end
      if (hit) begin
         region_hit           = 1'b1;
         outcome.found        = 1'b1;
         outcome.match_offset = region_bytes - OFFSET_W'(len);
         pending_outcomes.insert(pending_outcomes.size(), outcome);
      end else if (last && !region_hit) begin
         outcome = '0;
         pending_outcomes.insert(pending_outcomes.size(), outcome);
      end
      if (last) clear_region_state();
   endfunction

   // ------------------------------------------------------------------
   // Request and register drivers
   // ------------------------------------------------------------------

   // Offers one byte and waits until it is accepted. Valid is left high so
   // back-to-back requests need no extra assignment; the next caller either
   // drives new data or drops valid for a gap.
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (src_idling && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mem_byte  <= value;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_scan_result(value, last);
      bytes_sent++;
   endtask

   task automatic send_region(input logic [7:0] region [$]);
      foreach (region[i]) send_byte(region[i], i == region.size() - 1);
      regions_sent++;
   endtask

   // Stops offering and waits until every predicted outcome has come back,
   // then a further settling time, so that the block is idle afterwards.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr valid high; load_pattern lowers it after the last write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] reg_sel,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= reg_sel;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (reg_sel)
         CSR_PATTERN_0: pat_words[0] = data;
         CSR_PATTERN_1: pat_words[1] = data;
         CSR_PATTERN_2: pat_words[2] = data;
         CSR_PATTERN_3: pat_words[3] = data;
         CSR_WILDCARD:  wild_bits    = data[31:0];
         CSR_LENGTH:    pat_len_cfg  = data[CFG_LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Writes every register once the block is idle. Unused upper data bits
   // carry random junk, which the block must ignore.
   task automatic load_pattern(input logic [PAT_BITS-1:0]  pat,
                               input logic [31:0]          wild,
                               input logic [CFG_LEN_W-1:0] len_cfg);
      logic [CSR_DATA_W-1:0] junk;
      junk = {$urandom(), $urandom()};
      drain_results();
      write_reg(CSR_PATTERN_0, pat[0 * WORD_W +: WORD_W]);
      write_reg(CSR_PATTERN_1, pat[1 * WORD_W +: WORD_W]);
      write_reg(CSR_PATTERN_2, pat[2 * WORD_W +: WORD_W]);
      write_reg(CSR_PATTERN_3, pat[3 * WORD_W +: WORD_W]);
      write_reg(CSR_WILDCARD, {junk[CSR_DATA_W-1:32], wild});
      write_reg(CSR_LENGTH, {junk[CSR_DATA_W-1:CFG_LEN_W], len_cfg});
      csr_bus.valid <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] %s", $time, msg);
   endtask

   // ------------------------------------------------------------------
   // Result checker and receiver ready control
   // ------------------------------------------------------------------

   // Each accepted result is compared with the oldest pending outcome. The
   // same process decides ready for the next cycle: a long hold when one is
   // requested, random stall bursts when idling is on, otherwise always ready.
   initial begin : result_sink
      int         stall_left;
      int         hold_left;
      result_type want;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outcomes.size() == 0) begin
               report_error($sformatf("result with nothing pending: found=%0b offset=%0d",
                                      rsp_bus.found, rsp_bus.match_offset));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_bus.found !== want.found
                   || rsp_bus.match_offset !== want.match_offset) begin
                  report_error($sformatf(
                     "mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                     want.found, want.match_offset, rsp_bus.found, rsp_bus.match_offset));
               end
               if (want.found) hits_seen++;
               else misses_seen++;
            end
         end
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (snk_idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Registers at reset: all-zero pattern, no wildcards, length one. A lone
   // 0xFF ends without a match; in the second region the zero byte matches
   // on the last byte, so a found result comes and no not-found follows.
   task automatic test_reset_defaults();
      send_region({8'hFF});
      send_region({8'h5A, 8'h00});
   endtask

   // Length zero acts as one; length 63 acts as the full window, so a
   // two-byte region is too short to match an all-ones pattern.
   task automatic test_length_extremes();
      load_pattern('1, 32'h0, 6'd0);
      send_region({8'hFF});
      load_pattern('1, 32'h0, 6'd63);
      send_region({8'hFF, 8'hFF});
   endtask

   // Pattern "C?" of length two: a C at the end of a region lacks the byte
   // that the trailing wildcard needs, while C followed by anything matches.
   task automatic test_trailing_wildcard();
      load_pattern(PAT_BITS'(8'h43), 32'h2, 6'd2);
      send_region({8'h10, 8'h43});
      send_region({8'h43, 8'h99});
   endtask

   // Pattern "AAB" against "AAAB": the failed partial match at offset 0 must
   // not hide the real one starting at offset 1.
   task automatic test_restart_overlap();
      load_pattern(PAT_BITS'(24'h424141), 32'h0, 6'd3);
      send_region({8'h41, 8'h41, 8'h41, 8'h42});
   endtask

   // Only the first match of a region is reported; later matches and the
   // last byte stay silent.
   task automatic test_after_match();
      load_pattern(PAT_BITS'(8'h77), 32'h0, 6'd1);
      send_region({8'h77, 8'h77, 8'h77});
   endtask

   // Every byte matches and ends its region, so every request yields a
   // result. The receiver holds off for a long stretch while the sender keeps
   // offering, which fills the output stage and must stall req_bus. The
   // sender then pauses until everything has drained.
   task automatic test_output_backpressure();
      bit saved_src;
      bit saved_snk;
      saved_src = src_idling;
      saved_snk = snk_idling;
      load_pattern('0, 32'hFFFF_FFFF, 6'd1);
      src_idling       = 1'b0;
      snk_idling       = 1'b0;
      rsp_hold_request = LONG_HOLD;
      repeat (24) send_region({8'($urandom())});
      drain_results();
      src_idling = saved_src;
      snk_idling = saved_snk;
   endtask

   // Random phases, each with its own configuration. Most regions carry an
   // embedded pattern instance (sometimes with one bit flipped), and half the
   // phases draw all bytes from a two-value alphabet so that overlapping
   // partial matches are common.
   task automatic test_random_scan(input int phases, input int per_phase,
                                   input bit with_idling);
      logic [PAT_BITS-1:0]  pat;
      logic [31:0]          wild;
      logic [CFG_LEN_W-1:0] len_cfg;
      logic [7:0]           alphabet [2];
      logic [7:0]           region [$];
      int unsigned          len;
      int unsigned          span;
      int unsigned          at;
      int                   sent;
      bit                   narrow;
      src_idling = with_idling;
      snk_idling = with_idling;
      for (int p = 0; p < phases; p++) begin
         narrow      = $urandom_range(0, 1);
         alphabet[0] = 8'($urandom());
         alphabet[1] = 8'($urandom());
         for (int i = 0; i < PAT_BYTES; i++) begin
            pat[i * 8 +: 8] = narrow ? alphabet[$urandom_range(0, 1)] : 8'($urandom());
         end
         case ($urandom_range(0, 9))
            0:       pat = '0;
            1:       pat = '1;
            default: ;
         endcase
         case ($urandom_range(0, 7))
            0:       len_cfg = 6'd1;
            1:       len_cfg = 6'd32;
            2:       len_cfg = 6'd0;
            3:       len_cfg = 6'($urandom_range(33, 63));
            4:       len_cfg = 6'($urandom_range(13, 31));
            default: len_cfg = 6'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       wild = 32'h0;
            1:       wild = 32'hFFFF_FFFF;
            2:       wild = $urandom() & $urandom() & $urandom();
            default: wild = $urandom() & $urandom();
         endcase
         load_pattern(pat, wild, len_cfg);
         len  = active_length();
         sent = 0;
         while (sent < per_phase) begin
            if ($urandom_range(0, 9) == 0) span = $urandom_range(1, 4 * len + 40);
            else span = $urandom_range(1, len + 16);
            region = {};
            for (int i = 0; i < span; i++) begin
               region.insert(region.size(),
                             narrow ? alphabet[$urandom_range(0, 1)] : 8'($urandom()));
            end
            if (span >= len && $urandom_range(0, 2) != 0) begin
               at = $urandom_range(0, span - len);
               for (int i = 0; i < len; i++) begin
                  if (!wild[i]) region[at + i] = pattern_byte(i);
               end
               // A broken instance: one bit flipped somewhere in it.
               if ($urandom_range(0, 3) == 0) begin
                  region[at + $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
               end
            end
            send_region(region);
            sent += span;
         end
      end
      drain_results();
   endtask

   // Waits a bounded time for the last outcomes; whatever is still pending
   // afterwards never arrived.
   task automatic finish_run();
      int         waited;
      result_type lost;
      waited = 0;
      while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_outcomes.size() != 0) begin
         lost = pending_outcomes.pop_front();
         report_error($sformatf("missing result: expected found=%0b offset=%0d",
                                lost.found, lost.match_offset));
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.mem_byte  <= 8'd0;
      req_bus.last_byte <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= CSR_PATTERN_0;
      csr_bus.wdata     <= '0;
      foreach (pat_words[i]) pat_words[i] = '0;
      wild_bits   = '0;
      pat_len_cfg = CFG_LEN_W'(1);
      clear_region_state();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      src_idling = 1'b1;
      snk_idling = 1'b1;
      test_reset_defaults();
      test_length_extremes();
      test_trailing_wildcard();
      test_restart_overlap();
      test_after_match();
      test_output_backpressure();
      test_random_scan(11, 115, 1'b1);
      // The closing stretch runs at full rate with no idling on either side.
      test_random_scan(3, 115, 1'b0);
      finish_run();

      $display("covered %0d bytes in %0d regions over %0d cycles", bytes_sent,
               regions_sent, cycle_count);
      $display("checked %0d matches and %0d not-found outcomes, %0d mismatches",
               hits_seen, misses_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("wildcard_byte_pattern_scan_unit_tb: clean");
      end else begin
         $display("wildcard_byte_pattern_scan_unit_tb: errors");
      end
      $finish;
   end

endmodule
